### rtl/four_channel_moving_average_unit_assert.svh
`ifndef FOUR_CHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define FOUR_CHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define FCMA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fcma_pkg.sv
package fcma_pkg;

	localparam int unsigned TEMP_W  = 15;
	localparam int unsigned HUM_W   = 14;
	localparam int unsigned PRESS_W = 17;
	localparam int unsigned RAIN_W  = 12;

	localparam int unsigned WINDOW_DEF = 5;
	// quotient bits resolved per cycle in each divider lane while it steps
	localparam int unsigned DIV_STEPS  = 8;

	localparam int unsigned CFG_AW    = 3;
	localparam int unsigned CFG_DW    = 32;
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_RAIN_THRESHOLD = '0;
	localparam logic [RAIN_W-1:0] RAIN_THR_RESET = 12'd2000;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_sample;
		logic [HUM_W-1:0]         humidity_sample;
		logic [PRESS_W-1:0]       pressure_sample;
		logic [RAIN_W-1:0]        rain_sample;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_mean;
		logic [HUM_W-1:0]         humidity_mean;
		logic [PRESS_W-1:0]       pressure_mean;
		logic [RAIN_W-1:0]        rain_mean;
		logic                     rain_flag;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

### rtl/fcma_cell.sv
module fcma_cell (
	input  logic              clk,
	input  logic              shift,
	input  fcma_pkg::sample_t d,
	output fcma_pkg::sample_t q
);
	import fcma_pkg::*;

	sample_t data_q;

	// one window slot; takes its left neighbor's word on every accepted sample
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

### rtl/fcma_div.sv
module fcma_div #(
	parameter int unsigned DW    = 21,
	parameter int unsigned CW    = 3,
	parameter int unsigned STEPS = fcma_pkg::DIV_STEPS,
	parameter int unsigned ITER  = 3
) (
	input  logic                 clk,
	input  fcma_pkg::div_ctrl_t  ctrl,
	input  logic [DW-1:0]        dividend,
	input  logic [CW-1:0]        divisor,
	output logic [DW-1:0]        quotient
);
	import fcma_pkg::*;

	localparam int unsigned PW = ITER * STEPS;

	logic [PW-1:0] num_q;
	logic [CW:0]   rem_q;
	logic [CW-1:0] den_q;
	logic [PW-1:0] num_d;
	logic [CW:0]   rem_d;

	// restoring division, STEPS quotient bits per cycle while ctrl.step is set; quotient fills num from the bottom
	always_comb begin
		logic [PW-1:0] num;
		logic [CW:0]   rem;
		num = num_q;
		rem = rem_q;
		for (int k = 0; k < int'(STEPS); k++) begin
			rem = {rem[CW-1:0], num[PW-1]};
			num = {num[PW-2:0], 1'b0};
			if (rem >= {1'b0, den_q}) begin
				rem    = rem - {1'b0, den_q};
				num[0] = 1'b1;
			end
		end
		num_d = num;
		rem_d = rem;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q <= PW'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (ctrl.step) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
	end

	assign quotient = num_q[DW-1:0];

endmodule

### rtl/four_channel_moving_average_unit.sv
// Flow: after its sample word is accepted, a result word passes the load state,
// the divide state and the done state, and is written once the output is free.
// The block takes no new sample word while the divider lanes, which resolve
// 8 quotient bits per cycle, are busy; the next word is taken as a result is written.
// Reset (arst_n low): running sums, fill count, control and output valid clear,
// rain_threshold returns to 2000; window cells are not cleared.
module four_channel_moving_average_unit #(
	parameter int unsigned WINDOW = fcma_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  fcma_pkg::sample_t             sample,
	output logic                          mean_valid,
	input  logic                          mean_ready,
	output fcma_pkg::result_t             mean,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcma_pkg::CFG_AW-1:0]   paddr,
	input  logic [fcma_pkg::CFG_DW-1:0]   pwdata,
	output logic [fcma_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready
);
	import fcma_pkg::*;

	localparam int unsigned CW   = $clog2(WINDOW + 1);
	localparam int unsigned TS_W = TEMP_W + CW;
	localparam int unsigned HS_W = HUM_W + CW;
	localparam int unsigned PS_W = PRESS_W + CW;
	localparam int unsigned RS_W = RAIN_W + CW;
	localparam int unsigned M1   = (TS_W > HS_W) ? TS_W : HS_W;
	localparam int unsigned M2   = (PS_W > RS_W) ? PS_W : RS_W;
	localparam int unsigned MAX_DW = (M1 > M2) ? M1 : M2;
	localparam int unsigned ITER = (MAX_DW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int unsigned IW   = (ITER > 1) ? $clog2(ITER) : 1;

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_DONE} state_t;

	state_t           state_q;
	logic [IW-1:0]    cnt_q;
	logic             neg_q;
	logic             mean_valid_q;
	result_t          mean_q;
	logic [RAIN_W-1:0] thr_q;

	logic [CW-1:0]         fill_q;
	logic signed [TS_W-1:0] ts_q;
	logic [HS_W-1:0]       hs_q;
	logic [PS_W-1:0]       ps_q;
	logic [RS_W-1:0]       rs_q;

	sample_t chain [WINDOW+1];
	sample_t oldest;
	logic    accept, full, out_free, cfg_wr;
	div_ctrl_t ctrl;

	logic [TS_W-1:0] t_mag, t_quo;
	logic [HS_W-1:0] h_quo;
	logic [PS_W-1:0] p_quo;
	logic [RS_W-1:0] r_quo;
	result_t         res;

	// window as a shift chain: newest sample enters cell 0, oldest leaves the last cell
	assign chain[0] = sample;
	for (genvar i = 0; i < int'(WINDOW); i++) begin : g_cell
		fcma_cell u_cell (
			.clk   (clk),
			.shift (accept),
			.d     (chain[i]),
			.q     (chain[i+1])
		);
	end
	assign oldest = chain[WINDOW];

	assign out_free     = !mean_valid_q || mean_ready;
	assign sample_ready = (state_q == S_IDLE) || ((state_q == S_DONE) && out_free);
	assign accept       = sample_valid && sample_ready;
	assign full         = (fill_q == CW'(WINDOW));

	// running sums: add the new word, drop the one falling off the end once full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ts_q   <= '0;
			hs_q   <= '0;
			ps_q   <= '0;
			rs_q   <= '0;
		end else if (accept) begin
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
			ts_q <= ts_q + TS_W'($signed(sample.temperature_sample))
				- (full ? TS_W'($signed(oldest.temperature_sample)) : TS_W'(0));
			hs_q <= hs_q + HS_W'(sample.humidity_sample)
				- (full ? HS_W'(oldest.humidity_sample) : HS_W'(0));
			ps_q <= ps_q + PS_W'(sample.pressure_sample)
				- (full ? PS_W'(oldest.pressure_sample) : PS_W'(0));
			rs_q <= rs_q + RS_W'(sample.rain_sample)
				- (full ? RS_W'(oldest.rain_sample) : RS_W'(0));
		end
	end

	assign t_mag = ts_q[TS_W-1] ? (~ts_q + 1'b1) : ts_q;

	assign ctrl.load = (state_q == S_LOAD);
	assign ctrl.step = (state_q == S_DIV);

	fcma_div #(.DW(TS_W), .CW(CW), .STEPS(DIV_STEPS), .ITER(ITER)) u_div_t (
		.clk(clk), .ctrl(ctrl), .dividend(t_mag), .divisor(fill_q), .quotient(t_quo)
	);
	fcma_div #(.DW(HS_W), .CW(CW), .STEPS(DIV_STEPS), .ITER(ITER)) u_div_h (
		.clk(clk), .ctrl(ctrl), .dividend(hs_q), .divisor(fill_q), .quotient(h_quo)
	);
	fcma_div #(.DW(PS_W), .CW(CW), .STEPS(DIV_STEPS), .ITER(ITER)) u_div_p (
		.clk(clk), .ctrl(ctrl), .dividend(ps_q), .divisor(fill_q), .quotient(p_quo)
	);
	fcma_div #(.DW(RS_W), .CW(CW), .STEPS(DIV_STEPS), .ITER(ITER)) u_div_r (
		.clk(clk), .ctrl(ctrl), .dividend(rs_q), .divisor(fill_q), .quotient(r_quo)
	);

	// truncation toward zero: divide the magnitude, then restore the sign
	always_comb begin
		res.temperature_mean = neg_q ? (~t_quo[TEMP_W-1:0] + 1'b1) : t_quo[TEMP_W-1:0];
		res.humidity_mean    = h_quo[HUM_W-1:0];
		res.pressure_mean    = p_quo[PRESS_W-1:0];
		res.rain_mean        = r_quo[RAIN_W-1:0];
		res.rain_flag        = (r_quo[RAIN_W-1:0] < thr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			neg_q        <= 1'b0;
			mean_valid_q <= 1'b0;
			mean_q       <= '0;
		end else begin
			if (mean_valid_q && mean_ready) begin
				mean_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					neg_q   <= ts_q[TS_W-1];
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IW'(ITER - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						mean_valid_q <= 1'b1;
						mean_q       <= res;
						state_q      <= accept ? S_LOAD : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign mean_valid = mean_valid_q;
	assign mean       = mean_q;

	// register file: one word at byte address 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[CFG_AW-1:2] == REG_RAIN_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RAIN_THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[RAIN_W-1:0];
		end
	end

	assign prdata = (paddr[CFG_AW-1:2] == REG_RAIN_THRESHOLD) ? CFG_DW'(thr_q) : '0;

endmodule

### rtl/fcma_checker.sv
`include "four_channel_moving_average_unit_assert.svh"

module fcma_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic                          mean_valid,
	input logic                          mean_ready,
	input fcma_pkg::result_t             mean,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [fcma_pkg::CFG_AW-1:0]   paddr,
	input logic [fcma_pkg::CFG_DW-1:0]   pwdata,
	input logic [fcma_pkg::CFG_DW-1:0]   prdata,
	input logic                          pready
);
	import fcma_pkg::*;

	// a stalled result word holds
	`FCMA_ASSERT_NEXT(a_mean_hold, mean_valid && !mean_ready, mean_valid && $stable(mean), "result word dropped or changed while stalled")
	// one word in the divider at a time: no accept during load and first divide cycle
	`FCMA_ASSERT_NEXT(a_ready_gap, sample_valid && sample_ready, !sample_ready ##1 !sample_ready, "sample taken while divider busy")
	// threshold readback shows the last write
	`FCMA_ASSERT_SAME(a_thr_readback, (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2], prdata == CFG_DW'($past(pwdata[RAIN_W-1:0])), "threshold readback mismatch")

endmodule

bind four_channel_moving_average_unit fcma_checker u_fcma_checker (.*);
